// ===== rtl/k_core_peeling_core_macros.svh =====
// ----------------------------------------------------------------------------
// k-core peeling assertion macros
// shared property wrappers clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef K_CORE_PEELING_CORE_MACROS_SVH
`define K_CORE_PEELING_CORE_MACROS_SVH

// same-cycle implication
`define KCP_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define KCP_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/kcp_pkg.sv =====
// ----------------------------------------------------------------------------
// kcp_pkg
// sizes, codes and controller/datapath interface types of the k-core peeler
// ----------------------------------------------------------------------------
package kcp_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int NCNT_W    = NODE_W + 1;
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int ECNT_W    = EDGE_W + 1;
    localparam int DEG_W     = 14;
    localparam int K_W       = 14;
    localparam int NC_W      = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_K_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;

    localparam logic [K_W-1:0]  K_RESET  = 14'd2;
    localparam logic [NC_W-1:0] NC_RESET = 11'd1024;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ORDER   = 2'd2,
        ST_NOT_RUN = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FILL_INIT,
        OP_FILL,
        OP_STORE,
        OP_CLEAR,
        OP_QRD,
        OP_RESULT,
        OP_RUN_INIT,
        OP_RC_RD,
        OP_RC_WR,
        OP_PK_POP,
        OP_PK_DEAD,
        OP_PK_BEGIN,
        OP_PK_END,
        OP_PK_EDGE,
        OP_PK_NBR,
        OP_PK_UPD,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t res_status;
        logic    res_query;
    } kcp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  order_err;
        logic  full;
        logic  fill_done;
        logic  rc_last;
        logic  wl_nonempty;
        logic  edge_left;
        logic  t_in_use;
        logic  done;
    } kcp_stat_t;

endpackage

// ===== rtl/kcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcp_ctrl
// sequencer for load, run, query and clear; owns the result beat valid
// ----------------------------------------------------------------------------
module kcp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  kcp_pkg::kcp_stat_t st,
    output kcp_pkg::kcp_cmd_t  cmd
);
    import kcp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FILL_INIT, S_FILL, S_STORE, S_QRD, S_CLEAR,
        S_RUN_INIT, S_RC_RD, S_RC_WR, S_PK_POP, S_PK_DEAD, S_PK_BEGIN,
        S_PK_END, S_PK_EDGE, S_PK_NBR, S_PK_UPD, S_FINISH, S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_status_reg, res_status_next;
    logic    res_query_reg, res_query_next;
    logic    out_valid_reg, out_valid_next;
    op_t     op;
    logic    slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;

    // next state and command
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_query_next  = res_query_reg;
        op              = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_query_next  = 1'b0;
                case (st.kind)
                    KIND_LOAD:
                    begin
                        if (st.order_err)
                        begin
                            res_status_next = ST_ORDER;
                            state_next      = S_RESULT;
                        end
                        else if (st.full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_FILL_INIT;
                        end
                    end
                    KIND_RUN:   state_next = S_RUN_INIT;
                    KIND_QUERY:
                    begin
                        res_query_next  = 1'b1;
                        res_status_next = st.done ? ST_OK : ST_NOT_RUN;
                        state_next      = S_QRD;
                    end
                    default:    state_next = S_CLEAR;
                endcase
            end
            S_FILL_INIT:
            begin
                op         = OP_FILL_INIT;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                if (st.fill_done)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    op = OP_FILL;
                end
            end
            S_STORE:
            begin
                op         = OP_STORE;
                state_next = S_RESULT;
            end
            S_QRD:
            begin
                op         = OP_QRD;
                state_next = S_RESULT;
            end
            S_CLEAR:
            begin
                op         = OP_CLEAR;
                state_next = S_RESULT;
            end
            S_RUN_INIT:
            begin
                op         = OP_RUN_INIT;
                state_next = S_RC_RD;
            end
            S_RC_RD:
            begin
                op         = OP_RC_RD;
                state_next = S_RC_WR;
            end
            S_RC_WR:
            begin
                op         = OP_RC_WR;
                state_next = st.rc_last ? S_PK_POP : S_RC_RD;
            end
            S_PK_POP:
            begin
                if (st.wl_nonempty)
                begin
                    op         = OP_PK_POP;
                    state_next = S_PK_DEAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_PK_DEAD:
            begin
                op         = OP_PK_DEAD;
                state_next = S_PK_BEGIN;
            end
            S_PK_BEGIN:
            begin
                op         = OP_PK_BEGIN;
                state_next = S_PK_END;
            end
            S_PK_END:
            begin
                op         = OP_PK_END;
                state_next = S_PK_EDGE;
            end
            S_PK_EDGE:
            begin
                op         = OP_PK_EDGE;
                state_next = st.edge_left ? S_PK_NBR : S_PK_POP;
            end
            S_PK_NBR:
            begin
                op         = OP_PK_NBR;
                state_next = st.t_in_use ? S_PK_UPD : S_PK_EDGE;
            end
            S_PK_UPD:
            begin
                op         = OP_PK_UPD;
                state_next = S_PK_EDGE;
            end
            S_FINISH:
            begin
                op         = OP_FINISH;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    op         = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = (out_valid_reg && !m_tready) || (op == OP_RESULT);
        cmd.op         = op;
        cmd.res_status = res_status_reg;
        cmd.res_query  = res_query_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_query_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_query_reg  <= res_query_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ===== rtl/kcp_datapath.sv =====
// ----------------------------------------------------------------------------
// kcp_datapath
// graph stores, degree table, worklist, counters and result register
// ----------------------------------------------------------------------------
module kcp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [23:0]                       s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              cfg_valid,
    input  logic [kcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kcp_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  kcp_pkg::kcp_cmd_t                 cmd,
    output kcp_pkg::kcp_stat_t                st,
    output logic [15:0]                       m_tdata,
    output logic [1:0]                        m_tuser
);
    import kcp_pkg::*;

    // memories
    logic [EDGE_W-1:0] rs_mem  [MAX_NODES];
    logic [NODE_W-1:0] nbr_mem [MAX_EDGES];
    logic [NODE_W-1:0] wl_mem  [MAX_NODES];
    logic [DEG_W-1:0]  deg_mem [MAX_NODES];

    logic [EDGE_W-1:0] rs_q;
    logic [NODE_W-1:0] nbr_q, wl_q;
    logic [DEG_W-1:0]  deg_q;

    // control state
    logic [K_W-1:0]    k_reg;
    logic [NC_W-1:0]   nc_reg;
    logic [ECNT_W-1:0] count_reg;
    logic [NODE_W-1:0] last_reg;
    logic              seen_reg;
    logic              done_reg;
    logic [NCNT_W-1:0] fill_reg, idx_reg, head_reg, tail_reg;
    logic [ECNT_W-1:0] prev_reg, e_reg, end_reg;

    // item and walk payload
    kind_t             kind_reg;
    logic [NODE_W-1:0] src_reg, dst_reg, dead_reg, t_reg;
    logic [1:0]        out_status_reg;
    logic              out_alive_reg;
    logic [DEG_W-1:0]  out_deg_reg;

    logic [NC_W-1:0]   limit;
    logic [ECNT_W-1:0] rc_begin, rc_len, pk_begin, pk_end;
    logic [NCNT_W-1:0] dead_inc, rc_node;
    logic              rc_push, upd_push;

    logic [NODE_W-1:0] rs_raddr, deg_raddr;
    logic              rs_we, nbr_we, wl_we, deg_we;
    logic [NODE_W-1:0] rs_waddr, wl_waddr, deg_waddr, wl_wdata;
    logic [DEG_W-1:0]  deg_wdata;

    assign limit    = (nc_reg > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : nc_reg;
    assign dead_inc = {1'b0, dead_reg} + NCNT_W'(1);
    assign rc_node  = idx_reg - NCNT_W'(1);

    // row bounds while recounting and while walking a dead node
    assign rc_begin = (seen_reg && !idx_reg[NODE_W] && (idx_reg <= {1'b0, last_reg}))
                    ? {1'b0, rs_q} : count_reg;
    assign rc_len   = rc_begin - prev_reg;
    assign rc_push  = (idx_reg != '0) && ({1'b0, rc_node[NODE_W-1:0]} < limit)
                    && (rc_len < ECNT_W'(k_reg)) && (tail_reg < NCNT_W'(MAX_NODES));
    assign pk_begin = (seen_reg && (dead_reg <= last_reg)) ? {1'b0, rs_q} : count_reg;
    assign pk_end   = (!dead_inc[NODE_W] && seen_reg && (dead_inc <= {1'b0, last_reg}))
                    ? {1'b0, rs_q} : count_reg;
    assign upd_push = (deg_q != '0) && (deg_q == k_reg) && (tail_reg < NCNT_W'(MAX_NODES));

    // status to the controller
    always_comb
    begin
        st.kind        = kind_reg;
        st.order_err   = seen_reg && (src_reg < last_reg);
        st.full        = (count_reg >= ECNT_W'(MAX_EDGES));
        st.fill_done   = (fill_reg > {1'b0, src_reg});
        st.rc_last     = (idx_reg == NCNT_W'(MAX_NODES));
        st.wl_nonempty = (head_reg < tail_reg);
        st.edge_left   = (e_reg < end_reg);
        st.t_in_use    = ({1'b0, nbr_q} < limit);
        st.done        = done_reg;
    end

    // memory ports
    always_comb
    begin
        rs_raddr  = idx_reg[NODE_W-1:0];
        deg_raddr = src_reg;
        rs_we     = 1'b0;
        nbr_we    = 1'b0;
        wl_we     = 1'b0;
        deg_we    = 1'b0;
        rs_waddr  = fill_reg[NODE_W-1:0];
        wl_waddr  = tail_reg[NODE_W-1:0];
        wl_wdata  = rc_node[NODE_W-1:0];
        deg_waddr = rc_node[NODE_W-1:0];
        deg_wdata = rc_len;
        case (cmd.op)
            OP_FILL:     rs_we = !st.fill_done;
            OP_STORE:    nbr_we = 1'b1;
            OP_PK_DEAD:  rs_raddr = wl_q;
            OP_PK_BEGIN: rs_raddr = dead_inc[NODE_W-1:0];
            OP_PK_NBR:   deg_raddr = nbr_q;
            OP_RC_WR:
            begin
                deg_we = (idx_reg != '0);
                wl_we  = rc_push;
            end
            OP_PK_UPD:
            begin
                deg_we    = (deg_q != '0);
                deg_waddr = t_reg;
                deg_wdata = deg_q - DEG_W'(1);
                wl_we     = upd_push;
                wl_wdata  = t_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_waddr] <= count_reg[EDGE_W-1:0];
        if (nbr_we)
            nbr_mem[count_reg[EDGE_W-1:0]] <= dst_reg;
        if (wl_we)
            wl_mem[wl_waddr] <= wl_wdata;
        if (deg_we)
            deg_mem[deg_waddr] <= deg_wdata;
        rs_q  <= rs_mem[rs_raddr];
        nbr_q <= nbr_mem[e_reg[EDGE_W-1:0]];
        wl_q  <= wl_mem[head_reg[NODE_W-1:0]];
        deg_q <= deg_mem[deg_raddr];
    end

    // control registers, config and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= K_RESET;
            nc_reg    <= NC_RESET;
            count_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            prev_reg  <= '0;
            e_reg     <= '0;
            end_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_K_THRESHOLD))
                k_reg <= cfg_data;
            if (cfg_valid && (cfg_index == CFG_NODE_COUNT))
                nc_reg <= cfg_data[NC_W-1:0];
            case (cmd.op)
                OP_FILL_INIT: fill_reg <= seen_reg ? ({1'b0, last_reg} + NCNT_W'(1)) : '0;
                OP_FILL:
                begin
                    if (!st.fill_done)
                        fill_reg <= fill_reg + NCNT_W'(1);
                end
                OP_STORE:
                begin
                    count_reg <= count_reg + ECNT_W'(1);
                    last_reg  <= src_reg;
                    seen_reg  <= 1'b1;
                    done_reg  <= 1'b0;
                end
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    seen_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
                OP_RUN_INIT:
                begin
                    idx_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    prev_reg <= '0;
                end
                OP_RC_WR:
                begin
                    prev_reg <= rc_begin;
                    idx_reg  <= idx_reg + NCNT_W'(1);
                    if (rc_push)
                        tail_reg <= tail_reg + NCNT_W'(1);
                end
                OP_PK_POP:   head_reg <= head_reg + NCNT_W'(1);
                OP_PK_BEGIN: e_reg <= pk_begin;
                OP_PK_END:   end_reg <= pk_end;
                OP_PK_EDGE:
                begin
                    if (st.edge_left)
                        e_reg <= e_reg + ECNT_W'(1);
                end
                OP_PK_UPD:
                begin
                    if (upd_push)
                        tail_reg <= tail_reg + NCNT_W'(1);
                end
                OP_FINISH:   done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // item capture, walk payload and result beat
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                kind_reg <= kind_t'(s_tuser);
                src_reg  <= s_tdata[NODE_W-1:0];
                dst_reg  <= s_tdata[2*NODE_W-1:NODE_W];
            end
            OP_PK_DEAD: dead_reg <= wl_q;
            OP_PK_NBR:  t_reg <= nbr_q;
            OP_RESULT:
            begin
                out_status_reg <= cmd.res_status;
                if (cmd.res_query && (cmd.res_status == ST_OK)
                    && ({1'b0, src_reg} < nc_reg))
                begin
                    out_alive_reg <= (deg_q >= k_reg);
                    out_deg_reg   <= deg_q;
                end
                else
                begin
                    out_alive_reg <= 1'b0;
                    out_deg_reg   <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {1'b0, out_deg_reg, out_alive_reg};
    assign m_tuser = out_status_reg;

endmodule

// ===== rtl/k_core_peeling_core.sv =====
// ----------------------------------------------------------------------------
// k_core_peeling_core
// k-core decomposition by peeling over a row-ordered adjacency store
//
// channel   dir  beat contents
// s_*       in   tuser: kind; tdata: source_node, target_node
// m_*       out  tuser: status; tdata: alive, remaining_degree
// cfg_*     in   cfg_index 0 k_threshold, 1 node_count; cfg_data value
//
// one item at a time; each gives one result beat
// query and clear: dispatch, the read or clear step, result; rejected load: dispatch, result
// stored load: dispatch, fill init, row start fills, store, result; run: recount of every row,
// then per dead node a pop, row bounds and a neighbor walk with an update per in-use neighbor
// no clearing pass after reset; input waits while a result beat is stalled
// ----------------------------------------------------------------------------
module k_core_peeling_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // source_node[9:0], target_node[19:10]
    input  logic [1:0]                    s_tuser,   // kind[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // alive[0], remaining_degree[14:1]
    output logic [1:0]                    m_tuser,   // status[1:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kcp_pkg::CFG_DAT_W-1:0] cfg_data
);
    import kcp_pkg::*;

`include "k_core_peeling_core_macros.svh"

    kcp_cmd_t  cmd;
    kcp_stat_t st;

    assign cfg_ready = 1'b1;

    // sequencer
    kcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // stores and arithmetic
    kcp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // checks
    `KCP_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `KCP_ASSERT_IMP(a_result_slot_free, cmd.op == OP_RESULT, !m_tvalid || m_tready, "result overwrite")
    `KCP_ASSERT_IMP(a_pop_nonempty, cmd.op == OP_PK_POP, st.wl_nonempty, "worklist underflow")

endmodule
